### rtl/core/tks_pkg.sv
package tks_pkg;

    // Fixed field widths
    localparam int SCORE_W = 17;
    localparam int POS_W   = 16;
    localparam int TOP_W   = 5;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((SCORE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((POS_W + SCORE_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [TOP_W-1:0] TOP_COUNT_RESET = TOP_W'(5);

    // Register index, taken from paddr[2]
    localparam logic REG_TOP_COUNT = 1'b0;

    // Parameter defaults
    localparam int DEF_MAX_KEEP   = 16;
    localparam int DEF_INDEX_BITS = 16;

    // One step of the list update
    typedef struct packed {
        logic fire;  // apply the item held in the input register
        logic last;  // item closes the vector: snapshot and clear
    } step_t;

endpackage

### rtl/core/tks_list.sv
module tks_list
    import tks_pkg::*;
#(
    parameter int MAX_KEEP   = DEF_MAX_KEEP,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    localparam int CNT_W     = $clog2(MAX_KEEP + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [TOP_W-1:0]      top_count,
    input  step_t                 step,
    input  logic [SCORE_W-1:0]    new_score,
    input  logic [INDEX_BITS-1:0] new_pos,
    output logic [SCORE_W-1:0]    nxt_score [MAX_KEEP],
    output logic [INDEX_BITS-1:0] nxt_pos   [MAX_KEEP],
    output logic [CNT_W-1:0]      nxt_cnt
);

    localparam int K_W = (CNT_W > TOP_W) ? CNT_W : TOP_W;

    logic [SCORE_W-1:0]    score_reg [MAX_KEEP];
    logic [INDEX_BITS-1:0] pos_reg   [MAX_KEEP];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    logic [K_W-1:0]    k;
    logic [K_W-1:0]    cnt_eff;
    logic [MAX_KEEP-1:0] ge;
    logic              ge_last;
    logic              ins;

    // Effective list length and held count after a possible top_count cut
    always_comb begin
        k = (K_W'(top_count) > K_W'(MAX_KEEP)) ? K_W'(MAX_KEEP) : K_W'(top_count);
        cnt_eff = (K_W'(cnt_reg) > k) ? k : K_W'(cnt_reg);
    end

    // Parallel compare: held entries that stay ahead of the new score
    always_comb begin
        ge_last = 1'b0;
        for (int j = 0; j < MAX_KEEP; j++) begin
            ge[j] = (K_W'(j) < cnt_eff) && (score_reg[j] >= new_score);
            if (K_W'(j + 1) == k) begin
                ge_last = ge[j];
            end
        end
        ins = (k != '0) && !ge_last;
    end

    always_comb begin
        for (int j = 0; j < MAX_KEEP; j++) begin
            nxt_score[j] = score_reg[j];
            nxt_pos[j]   = pos_reg[j];
            if (ins && !ge[j]) begin
                if (j == 0) begin
                    nxt_score[j] = new_score;
                    nxt_pos[j]   = new_pos;
                end else if (ge[j-1]) begin
                    nxt_score[j] = new_score;
                    nxt_pos[j]   = new_pos;
                end else begin
                    nxt_score[j] = score_reg[j-1];
                    nxt_pos[j]   = pos_reg[j-1];
                end
            end
        end
        if (ins && (cnt_eff < k)) begin
            nxt_cnt = CNT_W'(cnt_eff + K_W'(1));
        end else begin
            nxt_cnt = CNT_W'(cnt_eff);
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (step.fire) begin
            cnt_next = step.last ? '0 : nxt_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.fire && ins) begin
            for (int j = 0; j < MAX_KEEP; j++) begin
                score_reg[j] <= nxt_score[j];
                pos_reg[j]   <= nxt_pos[j];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        K_W'(cnt_reg) <= K_W'(MAX_KEEP))
        else $error("held count above list depth");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step.fire && step.last |=> cnt_reg == '0)
        else $error("list not cleared after end of vector");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step.fire |=> $stable(cnt_reg))
        else $error("held count moved without an item");

endmodule

### rtl/core/tks_drain.sv
module tks_drain
    import tks_pkg::*;
#(
    parameter int MAX_KEEP   = DEF_MAX_KEEP,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    localparam int CNT_W     = $clog2(MAX_KEEP + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic [SCORE_W-1:0]    ld_score [MAX_KEEP],
    input  logic [INDEX_BITS-1:0] ld_pos   [MAX_KEEP],
    input  logic [CNT_W-1:0]      ld_cnt,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    logic [SCORE_W-1:0]    snap_score_reg [MAX_KEEP];
    logic [INDEX_BITS-1:0] snap_pos_reg   [MAX_KEEP];
    logic [CNT_W-1:0]      snap_cnt_reg;
    logic [CNT_W-1:0]      snap_cnt_next;
    logic                  pop;
    logic [INDEX_BITS+POS_W-1:0] pos_ext;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (snap_cnt_reg != '0);
    assign m_tlast  = (snap_cnt_reg == CNT_W'(1));
    assign free     = (snap_cnt_reg == '0) || (m_tlast && m_tready);

    assign pos_ext = {{POS_W{1'b0}}, snap_pos_reg[0]};
    assign m_tdata = M_DATA_W'({snap_score_reg[0], pos_ext[POS_W-1:0]});

    always_comb begin
        snap_cnt_next = snap_cnt_reg;
        if (load) begin
            snap_cnt_next = ld_cnt;
        end else if (pop) begin
            snap_cnt_next = snap_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_cnt_reg <= '0;
        end else begin
            snap_cnt_reg <= snap_cnt_next;
        end
    end

    // Load a whole sorted list, or advance the head by one entry
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int j = 0; j < MAX_KEEP; j++) begin
                snap_score_reg[j] <= ld_score[j];
                snap_pos_reg[j]   <= ld_pos[j];
            end
        end else if (pop) begin
            for (int j = 0; j < MAX_KEEP - 1; j++) begin
                snap_score_reg[j] <= snap_score_reg[j+1];
                snap_pos_reg[j]   <= snap_pos_reg[j+1];
            end
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("snapshot overwritten while results pending");

endmodule

### rtl/core/streaming_top_k_select_unit.sv
// Streaming top-k selector. Scores arrive one per item on the s_ stream and are
// numbered from 0 in arrival order (the number saturates at 2^INDEX_BITS-1).
// The block keeps the min(top_count, MAX_KEEP) highest scores in a sorted
// register list; a score enters only if the list is short or it beats the
// smallest held score strictly, and among equal scores the earlier one stays
// ahead. The item with s_tlast set is ranked like any other and then closes
// the vector: the list is copied to an output buffer, cleared, and sent on
// the m_ stream best first, one result per cycle while m_tready is high, m_tlast
// on the final one. With top_count zero the vector yields no result. Rate: one
// item per cycle, set by the parallel compare-and-shift of the list. An end item
// is held in the input register while the buffer still sends the previous
// vector's results, so vectors shorter than their result count see stalls.
// An end item passes the input register and then the output buffer before its
// first result. Write top_count at byte address 0 only while the block is idle.
module streaming_top_k_select_unit
    import tks_pkg::*;
#(
    parameter int MAX_KEEP   = DEF_MAX_KEEP,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // scores in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [16:0] score, rest zero
    input  logic                  s_tlast,   // end_of_vector
    // ranked results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [15:0] position, [32:16] best_score
    output logic                  m_tlast    // final_result
);

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;

    logic [TOP_W-1:0]      top_count_reg;
    logic                  in_vld_reg;
    logic [SCORE_W-1:0]    in_score_reg;
    logic                  in_last_reg;
    logic [INDEX_BITS-1:0] arrival_reg;
    logic [INDEX_BITS-1:0] arrival_next;

    step_t                 step;
    logic                  drain_free;
    logic                  s_acc;
    logic                  cfg_wr;

    logic [SCORE_W-1:0]    nxt_score [MAX_KEEP];
    logic [INDEX_BITS-1:0] nxt_pos   [MAX_KEEP];
    logic [CNT_W-1:0]      nxt_cnt;

    // APB: always ready, single register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOP_COUNT);
    assign prdata = (paddr[2] == REG_TOP_COUNT) ? CFG_DATA_W'(top_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= TOP_COUNT_RESET;
        end else if (cfg_wr) begin
            top_count_reg <= pwdata[TOP_W-1:0];
        end
    end

    // Apply the held item unless it closes a vector while results still drain
    assign step      = step_t'{fire: in_vld_reg && (!in_last_reg || drain_free),
                               last: in_last_reg};
    assign s_tready  = !in_vld_reg || step.fire;
    assign s_acc     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_acc) begin
            in_vld_reg <= 1'b1;
        end else if (step.fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_score_reg <= s_tdata[SCORE_W-1:0];
            in_last_reg  <= s_tlast;
        end
    end

    // Arrival number: saturate at the top, restart after each vector
    always_comb begin
        arrival_next = arrival_reg;
        if (step.fire) begin
            if (step.last) begin
                arrival_next = '0;
            end else if (arrival_reg != CNT_MAX) begin
                arrival_next = arrival_reg + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arrival_reg <= '0;
        end else begin
            arrival_reg <= arrival_next;
        end
    end

    tks_list #(
        .MAX_KEEP   (MAX_KEEP),
        .INDEX_BITS (INDEX_BITS)
    ) u_list (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .top_count (top_count_reg),
        .step      (step),
        .new_score (in_score_reg),
        .new_pos   (arrival_reg),
        .nxt_score (nxt_score),
        .nxt_pos   (nxt_pos),
        .nxt_cnt   (nxt_cnt)
    );

    tks_drain #(
        .MAX_KEEP   (MAX_KEEP),
        .INDEX_BITS (INDEX_BITS)
    ) u_drain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step.fire && step.last),
        .ld_score (nxt_score),
        .ld_pos   (nxt_pos),
        .ld_cnt   (nxt_cnt),
        .free     (drain_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
